// ===== hw/rtl/dssm_pkg.sv =====
// Package: shared types and constants for the dual stack shared memory core.
`default_nettype none

package dssm_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int STATUS_W  = 2;

	// Low two bits of func; bit 2 selects stack B.
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_LIST = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2
	} status_t;

endpackage : dssm_pkg

`default_nettype wire

// ===== hw/rtl/dssm_req_if.sv =====
// Interface: request channel (operation code and push value).
`default_nettype none

interface dssm_req_if
	import dssm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink   (input valid, input func, input push_value, output ready);
endinterface : dssm_req_if

`default_nettype wire

// ===== hw/rtl/dssm_rsp_if.sv =====
// Interface: response channel (data, status, last marker).
`default_nettype none

interface dssm_rsp_if
	import dssm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic [STATUS_W-1:0]      status;
	logic                     last;

	modport source (output valid, output data, output status, output last, input ready);
	modport sink   (input valid, input data, input status, input last, output ready);
endinterface : dssm_rsp_if

`default_nettype wire

// ===== hw/rtl/dual_stack_shared_memory_core.sv =====
// Top level: two stacks sharing one synchronous memory, A from the bottom, B from the top.
//
//  Channel | Dir | Payload                         | Transaction
//  --------+-----+---------------------------------+----------------------------------
//  req     | in  | func[2:0], push_value[31:0]     | one operation (push/pop/peek/list)
//  rsp     | out | data[31:0], status[1:0], last   | one result; list gives one per elem
//
//  Sequence: a request is taken in IDLE, then in RESP its single result is loaded into
//  the output register once it is free. A list of n elements gives n results, one
//  result per cycle unless rsp.ready stalls the output, set by the single memory read
//  port (one word per cycle, registered read data).
//  Reset: arst_n clears both counts, the sequencer and the output valid; the memory
//  itself is not cleared, only words written by a push are ever read.
//  Stalls: the output register holds a result while rsp.ready is low; the sequencer
//  waits in RESP and issues no new read until the register frees up. A request may
//  be accepted while the last result of the previous one still waits.
`default_nettype none

module dual_stack_shared_memory_core
	import dssm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dssm_req_if.sink     req,
	dssm_rsp_if.source   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // word address
	localparam int CW = $clog2(DEPTH + 1);                  // element count 0..DEPTH

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;

	// Stack occupancy
	logic [CW-1:0] count_a_q, count_b_q;

	// Per-request context
	logic          b_q;        // stack B selected
	logic          list_q;     // list in progress
	logic          use_mem_q;  // result data comes from memory read
	status_t       status_q;
	logic [AW-1:0] pos_q;      // element position being read, 0 = bottom

	// Output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;
	status_t                  out_status_q;
	logic                     out_last_q;

	// Shared storage and its registered read port
	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr, rd_pos;

	logic          accept, out_free, advance, more;
	logic          sel_b, full;
	op_t           op;
	logic [CW-1:0] n_in, n_dec;

	// Element position -> word address. B is mirrored from the top word.
	function automatic logic [AW-1:0] slot(input logic is_b, input logic [AW-1:0] pos);
		logic [AW-1:0] top;
		top = AW'(DEPTH - 1);
		return is_b ? (top - pos) : pos;
	endfunction

	assign sel_b = req.func[FUNC_W-1];
	assign op    = op_t'(req.func[1:0]);
	assign n_in  = sel_b ? count_b_q : count_a_q;
	assign n_dec = n_in - CW'(1);
	assign full  = ({1'b0, count_a_q} + {1'b0, count_b_q}) >= (CW+1)'(DEPTH);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign advance   = (state_q == S_RESP) && out_free;
	assign more      = list_q && (pos_q != '0);

	// Reads: top element on accept, next lower element when a list result is loaded.
	// Only one request is in flight, so a push write never races a read of that word.
	always_comb begin
		rd_pos  = (state_q == S_IDLE) ? n_dec[AW-1:0] : (pos_q - AW'(1));
		rd_addr = slot((state_q == S_IDLE) ? sel_b : b_q, rd_pos);
		rd_en   = (accept && (op != OP_PUSH) && (n_in != '0)) || (advance && more);
		wr_en   = accept && (op == OP_PUSH) && !full;
		wr_addr = slot(sel_b, n_in[AW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req.push_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer, counts and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_a_q    <= '0;
			count_b_q    <= '0;
			b_q          <= 1'b0;
			list_q       <= 1'b0;
			use_mem_q    <= 1'b0;
			status_q     <= STAT_OK;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_status_q <= STAT_OK;
			out_last_q   <= 1'b0;
		end else begin
			// load a new result, else drop the one taken by the sink
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						b_q     <= sel_b;
						list_q  <= 1'b0;
						state_q <= S_RESP;
						if (op == OP_PUSH) begin
							use_mem_q <= 1'b0;
							status_q  <= full ? STAT_OVERFLOW : STAT_OK;
							if (!full) begin
								if (sel_b) count_b_q <= count_b_q + CW'(1);
								else       count_a_q <= count_a_q + CW'(1);
							end
						end else if (n_in == '0) begin
							use_mem_q <= 1'b0;
							status_q  <= STAT_EMPTY;
						end else begin
							use_mem_q <= 1'b1;
							status_q  <= STAT_OK;
							list_q    <= (op == OP_LIST);
							pos_q     <= n_dec[AW-1:0];
							if (op == OP_POP) begin
								if (sel_b) count_b_q <= n_dec;
								else       count_a_q <= n_dec;
							end
						end
					end
				end
				S_RESP: begin
					if (advance) begin
						out_data_q   <= use_mem_q ? rd_data_q : '0;
						out_status_q <= status_q;
						out_last_q   <= !more;
						if (more) begin
							pos_q <= pos_q - AW'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_data_q;
	assign rsp.status = out_status_q;
	assign rsp.last   = out_last_q;

	// The two stacks never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_a_q} + {1'b0, count_b_q}) <= (CW+1)'(DEPTH))
		else $error("stack counts exceed memory depth");

	// A list walk stays inside the selected stack.
	a_list_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && list_q) |-> ({1'b0, pos_q} < (b_q ? count_b_q : count_a_q)))
		else $error("list position beyond stack top");

	// Error results carry zero data and end the request.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK) |-> (rsp.data == '0 && rsp.last))
		else $error("error result with data or without last");

	// An accepted request always produces a result stage next.
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RESP))
		else $error("accepted request did not enter RESP");

	// A push result is loaded the cycle after its acceptance when the output is free.
	a_push_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_PUSH) ##1 out_free |=> (rsp.valid && rsp.last))
		else $error("push result not delivered");

endmodule : dual_stack_shared_memory_core

`default_nettype wire
